/* src/clrm_pkg.sv */
// clrm_pkg: shared types, constants and register codes for the costmap layer
// resample merge block. No dependencies; used by every module under src.
package clrm_pkg;

  // default depth of the source grid memory
  localparam int unsigned MAX_SOURCE_CELLS_DEF = 65536;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_LAYER_ENABLED  = 3'd0,
    REG_MAX_COST       = 3'd1,
    REG_SOURCE_COLUMNS = 3'd2,
    REG_SOURCE_ROWS    = 3'd3,
    REG_SCALED_COSINE  = 3'd4,
    REG_SCALED_SINE    = 3'd5,
    REG_ORIGIN_X       = 3'd6,
    REG_ORIGIN_Y       = 3'd7
  } cfg_reg_t;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // reset values of the configuration registers
  localparam logic        RST_LAYER_ENABLED  = 1'b1;
  localparam logic [7:0]  RST_MAX_COST       = 8'd200;
  localparam logic [8:0]  RST_SOURCE_COLUMNS = 9'd256;
  localparam logic [8:0]  RST_SOURCE_ROWS    = 9'd256;
  localparam logic [31:0] RST_SCALED_COSINE  = 32'h0001_0000;
  localparam logic [31:0] RST_SCALED_SINE    = 32'h0000_0000;
  localparam logic [31:0] RST_ORIGIN_X       = 32'h0000_0000;
  localparam logic [31:0] RST_ORIGIN_Y       = 32'h0000_0000;

  // cost constants
  localparam logic [7:0] COST_MIN      = 8'd1;
  localparam logic [7:0] COST_MAX_CFG  = 8'd252;
  localparam logic [7:0] COST_LETHAL   = 8'd253;
  localparam logic [6:0] OCC_FULL      = 7'd100;
  localparam logic [5:0] ROUND_HALF    = 6'd50;

  // divide by 100 as multiply by 5243 and shift by 19, exact below 2^15
  localparam logic [12:0] DIV100_MUL   = 13'd5243;
  localparam int          DIV100_SHIFT = 19;

  // widths of the rotation datapath
  localparam int DELTA_W = 33;
  localparam int PROD_W  = 65;
  localparam int SUM_W   = 67;
  localparam int COORD_W = 9;
  localparam int FLAT_W  = 18;
  localparam int SCALE_W = 15;
  localparam int QUOT_W  = 28;

  typedef struct packed {
    logic        layer_enabled;
    logic [7:0]  max_cost;
    logic [8:0]  source_columns;
    logic [8:0]  source_rows;
    logic [31:0] scaled_cosine;
    logic [31:0] scaled_sine;
    logic [31:0] origin_x;
    logic [31:0] origin_y;
  } cfg_t;

  // one pipeline slot: a load or a query
  typedef struct packed {
    logic        valid;
    logic        query;
    logic [15:0] load_index;
    logic [7:0]  load_value;
    logic [7:0]  existing_cost;
  } slot_t;

endpackage

/* src/clrm_xform.sv */
// clrm_xform: four-stage rotation of world coordinates into source grid
// column and row, with floor and bounds check. Depends on clrm_pkg.
module clrm_xform (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               adv,
  input  clrm_pkg::cfg_t                     cfg,
  input  clrm_pkg::slot_t                    in_slot,
  input  logic [31:0]                        world_x,
  input  logic [31:0]                        world_y,
  output clrm_pkg::slot_t                    out_slot,
  output logic [clrm_pkg::COORD_W-1:0]       col,
  output logic [clrm_pkg::COORD_W-1:0]       row,
  output logic                               in_grid
);

  localparam int SUM_W   = clrm_pkg::SUM_W;
  localparam int PROD_W  = clrm_pkg::PROD_W;
  localparam int COORD_W = clrm_pkg::COORD_W;

  clrm_pkg::slot_t slot1, slot2, slot3;

  logic signed [clrm_pkg::DELTA_W-1:0] dx, dy;
  logic signed [clrm_pkg::PROD_W-1:0]  p_cx, p_sy, p_cy, p_sx;
  logic signed [SUM_W-1:0]             sum_col, sum_row;

  logic signed [31:0] cos_s, sin_s;
  logic               col_ok, row_ok;

  assign cos_s = signed'(cfg.scaled_cosine);
  assign sin_s = signed'(cfg.scaled_sine);

  // in range when the sum is in [0, 2^41) and the floored coordinate is below limit
  assign col_ok = (sum_col[SUM_W-1:32+COORD_W] == '0) &&
                  (sum_col[32+COORD_W-1:32] < cfg.source_columns);
  assign row_ok = (sum_row[SUM_W-1:32+COORD_W] == '0) &&
                  (sum_row[32+COORD_W-1:32] < cfg.source_rows);

  always_ff @(posedge clk) begin
    if (rst) begin
      slot1.valid    <= 1'b0;
      slot2.valid    <= 1'b0;
      slot3.valid    <= 1'b0;
      out_slot.valid <= 1'b0;
    end else if (adv) begin
      slot1    <= in_slot;
      slot2    <= slot1;
      slot3    <= slot2;
      out_slot <= slot3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dx      <= signed'({world_x[31], world_x}) - signed'({cfg.origin_x[31], cfg.origin_x});
      dy      <= signed'({world_y[31], world_y}) - signed'({cfg.origin_y[31], cfg.origin_y});
      p_cx    <= PROD_W'(cos_s) * PROD_W'(dx);
      p_sy    <= PROD_W'(sin_s) * PROD_W'(dy);
      p_cy    <= PROD_W'(cos_s) * PROD_W'(dy);
      p_sx    <= PROD_W'(sin_s) * PROD_W'(dx);
      sum_col <= SUM_W'(p_cx) + SUM_W'(p_sy);
      sum_row <= SUM_W'(p_cy) - SUM_W'(p_sx);
      col     <= sum_col[32+COORD_W-1:32];
      row     <= sum_row[32+COORD_W-1:32];
      in_grid <= col_ok && row_ok;
    end
  end

endmodule

/* src/clrm_cells.sv */
// clrm_cells: source grid memory stage; loads write and queries read in
// transaction order through one access slot. Depends on clrm_pkg.
module clrm_cells #(
  parameter int unsigned MAX_SOURCE_CELLS = clrm_pkg::MAX_SOURCE_CELLS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  clrm_pkg::cfg_t                cfg,
  input  clrm_pkg::slot_t               in_slot,
  input  logic [clrm_pkg::COORD_W-1:0]  col,
  input  logic [clrm_pkg::COORD_W-1:0]  row,
  input  logic                          in_grid,
  output clrm_pkg::slot_t               out_slot,
  output logic                          lookup_ok,
  output logic [7:0]                    cell_value
);

  localparam int AW = (MAX_SOURCE_CELLS > 1) ? $clog2(MAX_SOURCE_CELLS) : 1;

  logic [7:0] mem [MAX_SOURCE_CELLS];

  logic                         loaded;
  logic [clrm_pkg::FLAT_W-1:0]  flat;
  logic                         flat_ok, load_ok, is_load;
  logic [AW-1:0]                addr;

  assign flat    = clrm_pkg::FLAT_W'(row) * clrm_pkg::FLAT_W'(cfg.source_columns)
                 + clrm_pkg::FLAT_W'(col);
  assign flat_ok = 32'(flat) < 32'(MAX_SOURCE_CELLS);
  assign load_ok = 32'(in_slot.load_index) < 32'(MAX_SOURCE_CELLS);
  assign is_load = in_slot.valid && !in_slot.query;
  assign addr    = in_slot.query ? AW'(32'(flat)) : AW'(32'(in_slot.load_index));

  always_ff @(posedge clk) begin
    if (adv && is_load && load_ok) begin
      mem[addr] <= in_slot.load_value;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cell_value <= mem[addr];
    end
  end

  // loaded flag reflects only loads ahead of the query in this slot
  always_ff @(posedge clk) begin
    if (rst) begin
      loaded         <= 1'b0;
      out_slot.valid <= 1'b0;
    end else if (adv) begin
      if (is_load) begin
        loaded <= 1'b1;
      end
      out_slot <= in_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lookup_ok <= in_slot.query && cfg.layer_enabled && loaded && in_grid && flat_ok;
    end
  end

endmodule

/* src/clrm_scale.sv */
// clrm_scale: three-stage cost scaling of the source cell and merge with the
// existing master cost; last stage is the output register. Depends on clrm_pkg.
module clrm_scale (
  input  logic             clk,
  input  logic             rst,
  input  logic             adv,
  input  clrm_pkg::cfg_t   cfg,
  input  clrm_pkg::slot_t  in_slot,
  input  logic             lookup_ok,
  input  logic [7:0]       cell_value,
  output logic             out_valid,
  output logic [7:0]       new_cost,
  output logic             cost_raised,
  output logic             source_hit
);

  clrm_pkg::slot_t slot6, slot7;

  logic                          pos6, pos7;
  logic [clrm_pkg::SCALE_W-1:0]  scaled6;
  logic [clrm_pkg::QUOT_W-1:0]   quot7;

  logic                          positive;
  logic [6:0]                    occ;
  logic [7:0]                    cost_q, cost_c;
  logic                          raise;

  assign positive = lookup_ok && !cell_value[7] && (cell_value != 8'd0);
  assign occ      = (cell_value[6:0] > clrm_pkg::OCC_FULL) ? clrm_pkg::OCC_FULL
                                                            : cell_value[6:0];

  assign cost_q = quot7[clrm_pkg::DIV100_SHIFT+7:clrm_pkg::DIV100_SHIFT];

  always_comb begin
    cost_c = cost_q;
    if (cost_c > cfg.max_cost) begin
      cost_c = cfg.max_cost;
    end
    if (cost_c < clrm_pkg::COST_MIN) begin
      cost_c = clrm_pkg::COST_MIN;
    end
  end

  assign raise = pos7 && (slot7.existing_cost < clrm_pkg::COST_LETHAL) &&
                 (cost_c > slot7.existing_cost);

  always_ff @(posedge clk) begin
    if (rst) begin
      slot6.valid <= 1'b0;
      slot7.valid <= 1'b0;
      out_valid   <= 1'b0;
    end else if (adv) begin
      slot6     <= in_slot;
      slot7     <= slot6;
      out_valid <= slot7.valid && slot7.query;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pos6        <= positive;
      scaled6     <= clrm_pkg::SCALE_W'(cfg.max_cost) * clrm_pkg::SCALE_W'(occ)
                   + clrm_pkg::SCALE_W'(clrm_pkg::ROUND_HALF);
      pos7        <= pos6;
      quot7       <= clrm_pkg::QUOT_W'(scaled6) * clrm_pkg::QUOT_W'(clrm_pkg::DIV100_MUL);
      new_cost    <= raise ? cost_c : slot7.existing_cost;
      cost_raised <= raise;
      source_hit  <= pos7;
    end
  end

endmodule

/* src/costmap_layer_resample_merge.sv */
// costmap_layer_resample_merge: top level with configuration registers and
// stall control. Depends on clrm_pkg, clrm_xform, clrm_cells, clrm_scale.
//
//   channel   direction  signals                              content
//   s_axis    in         tvalid tready tdata[95:0] tuser[0]   load or query
//   m_axis    out        tvalid tready tdata[15:0]            query result
//   cfg       in         cfg_we cfg_addr[2:0] cfg_wdata[31:0]  register write
//
// one transaction per cycle while the pipeline advances; a query's result is
// registered into the output register, loads give no result and leave a bubble.
// the pipeline advances as one unit when the output register is empty or taken;
// the grid memory is accessed in a single stage, so loads and queries see it in
// transaction order. rst clears valid bits, the loaded flag and the registers;
// memory contents stay undefined until loaded.
module costmap_layer_resample_merge #(
  parameter int unsigned MAX_SOURCE_CELLS = clrm_pkg::MAX_SOURCE_CELLS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // load_index[15:0], load_value[23:16], world_x[55:24], world_y[87:56],
  // existing_cost[95:88]
  input  logic [95:0]                     s_axis_tdata,
  // mode[0]
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // new_cost[7:0], cost_raised[8], source_hit[9], zero fill[15:10]
  output logic [15:0]                     m_axis_tdata,
  input  logic                            cfg_we,
  input  logic [clrm_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [clrm_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  clrm_pkg::cfg_t  cfg;
  clrm_pkg::slot_t in_slot, xf_slot, mem_slot;

  logic                          adv;
  logic [clrm_pkg::COORD_W-1:0]  col, row;
  logic                          in_grid, lookup_ok;
  logic [7:0]                    cell_value, new_cost, mc;
  logic                          cost_raised, source_hit;

  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  assign in_slot.valid         = s_axis_tvalid;
  assign in_slot.query         = s_axis_tuser;
  assign in_slot.load_index    = s_axis_tdata[15:0];
  assign in_slot.load_value    = s_axis_tdata[23:16];
  assign in_slot.existing_cost = s_axis_tdata[95:88];

  // max_cost is clamped into its legal range on write
  always_comb begin
    mc = cfg_wdata[7:0];
    if (mc < clrm_pkg::COST_MIN) begin
      mc = clrm_pkg::COST_MIN;
    end
    if (mc > clrm_pkg::COST_MAX_CFG) begin
      mc = clrm_pkg::COST_MAX_CFG;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.layer_enabled  <= clrm_pkg::RST_LAYER_ENABLED;
      cfg.max_cost       <= clrm_pkg::RST_MAX_COST;
      cfg.source_columns <= clrm_pkg::RST_SOURCE_COLUMNS;
      cfg.source_rows    <= clrm_pkg::RST_SOURCE_ROWS;
      cfg.scaled_cosine  <= clrm_pkg::RST_SCALED_COSINE;
      cfg.scaled_sine    <= clrm_pkg::RST_SCALED_SINE;
      cfg.origin_x       <= clrm_pkg::RST_ORIGIN_X;
      cfg.origin_y       <= clrm_pkg::RST_ORIGIN_Y;
    end else if (cfg_we) begin
      case (clrm_pkg::cfg_reg_t'(cfg_addr))
        clrm_pkg::REG_LAYER_ENABLED:  cfg.layer_enabled  <= cfg_wdata[0];
        clrm_pkg::REG_MAX_COST:       cfg.max_cost       <= mc;
        clrm_pkg::REG_SOURCE_COLUMNS: cfg.source_columns <= cfg_wdata[8:0];
        clrm_pkg::REG_SOURCE_ROWS:    cfg.source_rows    <= cfg_wdata[8:0];
        clrm_pkg::REG_SCALED_COSINE:  cfg.scaled_cosine  <= cfg_wdata;
        clrm_pkg::REG_SCALED_SINE:    cfg.scaled_sine    <= cfg_wdata;
        clrm_pkg::REG_ORIGIN_X:       cfg.origin_x       <= cfg_wdata;
        clrm_pkg::REG_ORIGIN_Y:       cfg.origin_y       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  clrm_xform u_xform (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .cfg      (cfg),
    .in_slot  (in_slot),
    .world_x  (s_axis_tdata[55:24]),
    .world_y  (s_axis_tdata[87:56]),
    .out_slot (xf_slot),
    .col      (col),
    .row      (row),
    .in_grid  (in_grid)
  );

  clrm_cells #(
    .MAX_SOURCE_CELLS (MAX_SOURCE_CELLS)
  ) u_cells (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .cfg        (cfg),
    .in_slot    (xf_slot),
    .col        (col),
    .row        (row),
    .in_grid    (in_grid),
    .out_slot   (mem_slot),
    .lookup_ok  (lookup_ok),
    .cell_value (cell_value)
  );

  clrm_scale u_scale (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .cfg         (cfg),
    .in_slot     (mem_slot),
    .lookup_ok   (lookup_ok),
    .cell_value  (cell_value),
    .out_valid   (m_axis_tvalid),
    .new_cost    (new_cost),
    .cost_raised (cost_raised),
    .source_hit  (source_hit)
  );

  assign m_axis_tdata = {6'd0, source_hit, cost_raised, new_cost};

endmodule

/* dv/tb_costmap_layer_resample_merge.sv */
// tb_costmap_layer_resample_merge: self-checking testbench for the costmap layer
// resample merge block. Depends on clrm_pkg and costmap_layer_resample_merge.
// A directed table, then random loads and queries under several register settings.
module tb_costmap_layer_resample_merge;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_QUERY = 1'b1;
  localparam int unsigned GRID_CELLS = 65536;
  localparam int FLUSH_CYCLES = 16;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 165;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [7:0] cost;
    logic       raised;
    logic       hit;
  } merge_t;

  typedef enum logic [1:0] {ROW_LOAD, ROW_QUERY, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [15:0] idx;
    logic [7:0]  val;
    logic [31:0] wx;
    logic [31:0] wy;
    logic [7:0]  ex;
    logic        typed;
    merge_t      want;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        cfg_we = 1'b0;
  logic [clrm_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [clrm_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  // shadow copy of the block state
  logic              sh_enabled;
  logic [7:0]        sh_max;
  logic [8:0]        sh_cols;
  logic [8:0]        sh_rows;
  logic signed [31:0] sh_cos;
  logic signed [31:0] sh_sin;
  logic signed [31:0] sh_ox;
  logic signed [31:0] sh_oy;
  logic              sh_loaded;
  logic [7:0]        shadow_grid [GRID_CELLS];
  bit                grid_written [GRID_CELLS];

  merge_t costs_due [$];
  int     mismatches = 0;
  int     tx_idle = 16;
  int     rx_idle = 83;

  // query rows name the cell by world position: with the reset rotation, the
  // integer part of the Q16.16 coordinate is the column or row
  row_t directed_rows [0:28] = '{
    '{ROW_QUERY, 16'd0, 8'd0, 32'h0, 32'h0, 8'd7, 1'b1, '{8'd7, 1'b0, 1'b0}},
    '{ROW_QUERY, 16'd0, 8'd0, 32'h7FFF_FFFF, 32'h8000_0000, 8'd255, 1'b1,
      '{8'd255, 1'b0, 1'b0}},
    '{ROW_LOAD, 16'd0, 8'd100, 32'h0, 32'h0, 8'd0, 1'b0, '0},
    '{ROW_QUERY, 16'd0, 8'd0, 32'h0, 32'h0, 8'd0, 1'b1, '{8'd200, 1'b1, 1'b1}},
    '{ROW_QUERY, 16'd0, 8'd0, 32'h0, 32'h0, 8'd253, 1'b1, '{8'd253, 1'b0, 1'b1}},
    '{ROW_QUERY, 16'd0, 8'd0, 32'h0, 32'h0, 8'd255, 1'b1, '{8'd255, 1'b0, 1'b1}},
    '{ROW_QUERY, 16'd0, 8'd0, 32'h0, 32'h0, 8'd254, 1'b1, '{8'd254, 1'b0, 1'b1}},
    '{ROW_QUERY, 16'd0, 8'd0, 32'h0, 32'h0, 8'd252, 1'b0, '0},
    '{ROW_LOAD, 16'd1, 8'hFF, 32'h0, 32'h0, 8'd0, 1'b0, '0},
    '{ROW_QUERY, 16'd0, 8'd0, 32'h0001_0000, 32'h0, 8'd5, 1'b1, '{8'd5, 1'b0, 1'b0}},
    '{ROW_LOAD, 16'd2, 8'd0, 32'h0, 32'h0, 8'd0, 1'b0, '0},
    '{ROW_QUERY, 16'd0, 8'd0, 32'h0002_0000, 32'h0, 8'd5, 1'b0, '0},
    '{ROW_LOAD, 16'd3, 8'd127, 32'h0, 32'h0, 8'd0, 1'b0, '0},
    '{ROW_QUERY, 16'd0, 8'd0, 32'h0003_0000, 32'h0, 8'd199, 1'b0, '0},
    '{ROW_LOAD, 16'd65535, 8'd1, 32'h0, 32'h0, 8'd0, 1'b0, '0},
    '{ROW_QUERY, 16'd0, 8'd0, 32'h00FF_0000, 32'h00FF_0000, 8'd0, 1'b0, '0},
    '{ROW_LOAD, 16'd256, 8'd50, 32'h0, 32'h0, 8'd0, 1'b0, '0},
    '{ROW_QUERY, 16'd0, 8'd0, 32'h0, 32'h0001_0000, 8'd0, 1'b0, '0},
    '{ROW_QUERY, 16'd0, 8'd0, 32'hFFFF_FFFF, 32'h0, 8'd9, 1'b1, '{8'd9, 1'b0, 1'b0}},
    '{ROW_QUERY, 16'd0, 8'd0, 32'h0100_0000, 32'h0, 8'd0, 1'b1, '{8'd0, 1'b0, 1'b0}},
    '{ROW_QUERY, 16'd0, 8'd0, 32'h0, 32'h8000_0000, 8'd0, 1'b1, '{8'd0, 1'b0, 1'b0}},
    '{ROW_LOAD, 16'd4, 8'h80, 32'h0, 32'h0, 8'd0, 1'b0, '0},
    '{ROW_QUERY, 16'd0, 8'd0, 32'h0004_0000, 32'h0, 8'd3, 1'b0, '0},
    '{ROW_LOAD, 16'd5, 8'd1, 32'h0, 32'h0, 8'd0, 1'b0, '0},
    '{ROW_QUERY, 16'd0, 8'd0, 32'h0005_0000, 32'h0000_FFFF, 8'd1, 1'b0, '0},
    '{ROW_QUERY, 16'd0, 8'd0, 32'h0005_8000, 32'h0, 8'd0, 1'b0, '0},
    '{ROW_CFG, {13'd0, clrm_pkg::REG_LAYER_ENABLED}, 8'd0, 32'h0, 32'h0, 8'd0, 1'b0, '0},
    '{ROW_QUERY, 16'd0, 8'd0, 32'h0, 32'h0, 8'd0, 1'b1, '{8'd0, 1'b0, 1'b0}},
    '{ROW_CFG, {13'd0, clrm_pkg::REG_LAYER_ENABLED}, 8'd0, 32'h1, 32'h0, 8'd0, 1'b0, '0}
  };

  costmap_layer_resample_merge i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata)
  );

  always #1 clk = ~clk;

  // floor of the rotated position; 1 when it lands on a cell of the grid
  function automatic logic locate_cell(input logic [31:0] wx, input logic [31:0] wy,
                                       output int unsigned flat);
    logic signed [67:0] dx, dy, cs, sn, tmp, col_acc, row_acc;
    logic [35:0] col, row;
    dx = 68'($signed(wx));
    tmp = 68'(sh_ox);
    dx = dx - tmp;
    dy = 68'($signed(wy));
    tmp = 68'(sh_oy);
    dy = dy - tmp;
    cs = 68'(sh_cos);
    sn = 68'(sh_sin);
    col_acc = cs * dx + sn * dy;
    row_acc = cs * dy - sn * dx;
    flat = 0;
    if (col_acc < 0 || row_acc < 0) return 1'b0;
    col = col_acc[67:32];
    row = row_acc[67:32];
    if (col >= 36'(sh_cols) || row >= 36'(sh_rows)) return 1'b0;
    flat = 32'(row[8:0]) * 32'(sh_cols) + 32'(col[8:0]);
    return flat < GRID_CELLS;
  endfunction

  function automatic merge_t merge_cost(input logic [31:0] wx, input logic [31:0] wy,
                                        input logic [7:0] ex);
    merge_t r;
    int unsigned flat;
    int v, occ, c;
    r = '{ex, 1'b0, 1'b0};
    if (sh_enabled && sh_loaded && locate_cell(wx, wy, flat)) begin
      v = int'($signed(shadow_grid[flat]));
      if (v > 0) begin
        occ = (v > 100) ? 100 : v;
        c = (int'(sh_max) * occ + 50) / 100;
        if (c > int'(sh_max)) c = int'(sh_max);
        if (c < 1) c = 1;
        r.hit = 1'b1;
        if (ex < clrm_pkg::COST_LETHAL && c > int'(ex)) begin
          r.cost = c[7:0];
          r.raised = 1'b1;
        end
      end
    end
    return r;
  endfunction

  function automatic logic [7:0] pick_occupancy();
    case ($urandom_range(0, 9))
      6: return 8'd0;
      7: return 8'($urandom_range(101, 127));
      8: return 8'($urandom_range(128, 255));
      9: return 8'd100;
      default: return 8'($urandom_range(1, 100));
    endcase
  endfunction

  task automatic note_mismatch(input string what, input merge_t want, input merge_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%s: expected cost %0d raised %0d hit %0d, got cost %0d raised %0d hit %0d",
               what, want.cost, want.raised, want.hit, got.cost, got.raised, got.hit);
  endtask

  task automatic push_item(input logic mode, input logic [95:0] data);
    @(negedge clk);
    while ($urandom_range(0, 99) < tx_idle) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= data;
    s_axis_tuser <= mode;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic send_load(input logic [15:0] idx, input logic [7:0] val);
    logic [95:0] noise;
    noise = {$urandom, $urandom, $urandom};
    push_item(MODE_LOAD, {noise[95:24], val, idx});
    shadow_grid[idx] = val;
    grid_written[idx] = 1'b1;
    sh_loaded = 1'b1;
  endtask

  // stop sending until every result is out and the pipeline has emptied
  task automatic drain_idle();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (costs_due.size() != 0) @(posedge clk);
    repeat (FLUSH_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input clrm_pkg::cfg_reg_t r, input logic [31:0] v);
    logic [7:0] m;
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= r;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (r)
      clrm_pkg::REG_LAYER_ENABLED:  sh_enabled = v[0];
      clrm_pkg::REG_MAX_COST: begin
        m = v[7:0];
        if (m < clrm_pkg::COST_MIN) m = clrm_pkg::COST_MIN;
        if (m > clrm_pkg::COST_MAX_CFG) m = clrm_pkg::COST_MAX_CFG;
        sh_max = m;
      end
      clrm_pkg::REG_SOURCE_COLUMNS: sh_cols = v[8:0];
      clrm_pkg::REG_SOURCE_ROWS:    sh_rows = v[8:0];
      clrm_pkg::REG_SCALED_COSINE:  sh_cos = v;
      clrm_pkg::REG_SCALED_SINE:    sh_sin = v;
      clrm_pkg::REG_ORIGIN_X:       sh_ox = v;
      clrm_pkg::REG_ORIGIN_Y:       sh_oy = v;
      default: ;
    endcase
  endtask

  task automatic program_phase(input int phase);
    logic [31:0] v [8];
    v[0] = {31'($urandom_range(0, 32'h7FFF_FFFF)), 1'b1};
    v[1] = {24'($urandom_range(0, 32'h00FF_FFFF)), 8'd252};
    v[2] = 32'd256;
    v[3] = 32'd256;
    v[4] = 32'h0001_0000;
    v[5] = 32'h0;
    v[6] = $urandom;
    v[7] = $urandom;
    case (phase)
      0: begin
        v[2] = {23'($urandom_range(0, 32'h007F_FFFF)), 9'd16};
        v[3] = 32'd16;
        v[4] = 32'h0002_0000;
        v[6] = 32'h0001_0000;
        v[7] = 32'hFFFE_0000;
      end
      1: begin
        v[1] = 32'd1;
        v[4] = 32'h0;
        v[5] = 32'h0001_0000;
      end
      2: begin
        v[0] = {31'($urandom_range(0, 32'h7FFF_FFFF)), 1'b0};
        v[1] = 32'd255;
        v[2] = 32'd37;
        v[3] = 32'd5;
        v[4] = 32'd46341;
        v[5] = 32'd46341;
      end
      3: begin
        v[1] = $urandom_range(1, 252);
        v[2] = 32'd1;
        v[3] = 32'd1;
        v[4] = 32'hFFFC_0000;
        v[5] = 32'h0001_2345;
      end
      4: begin
        v[1] = 32'd137;
        v[2] = 32'd300;
        v[3] = 32'd300;
        v[4] = 32'h0001_8000;
        v[5] = 32'hFFFF_B1E0;
      end
      5: begin
        v[1] = $urandom_range(0, 255);
        v[4] = 32'h7FFF_FFFF;
        v[5] = 32'h8000_0000;
        v[6] = 32'h8000_0000;
        v[7] = 32'h7FFF_FFFF;
      end
      6: begin
        v[1] = 32'd0;
        v[2] = 32'd0;
      end
      default: begin
        v[1] = $urandom;
        v[2] = $urandom_range(0, 511);
        v[3] = $urandom_range(0, 511);
        v[4] = $urandom;
        v[5] = $urandom;
      end
    endcase
    for (int r = 0; r < 8; r++) write_reg(clrm_pkg::cfg_reg_t'(r), v[r]);
  endtask

  // queries mostly aim at cells near the grid by inverting the rotation
  task automatic run_random(input int n);
    logic [31:0] wx, wy;
    logic [7:0] ex;
    logic [95:0] noise;
    int unsigned flat;
    int span_c, span_r;
    real cr, sr, den, u, w, dxr, dyr;
    longint dxl, dyl;
    for (int k = 0; k < n; k++) begin
      if (k == n / 2) drain_idle();
      if ($urandom_range(0, 99) < 30) begin
        if ($urandom_range(0, 9) < 7) begin
          flat = $urandom_range(0, (sh_rows == 0) ? 0 : sh_rows - 1) * 32'(sh_cols)
                 + $urandom_range(0, (sh_cols == 0) ? 0 : sh_cols - 1);
          send_load(flat[15:0], pick_occupancy());
        end else begin
          send_load(16'($urandom), 8'($urandom));
        end
      end else begin
        wx = $urandom;
        wy = $urandom;
        cr = $itor(sh_cos) / 65536.0;
        sr = $itor(sh_sin) / 65536.0;
        den = cr * cr + sr * sr;
        if ($urandom_range(0, 3) != 0 && den > 0.0) begin
          span_c = (sh_cols == 0) ? 4 : sh_cols + 2;
          span_r = (sh_rows == 0) ? 4 : sh_rows + 2;
          u = $itor($urandom_range(0, span_c - 1)) - 1.0 + $urandom_range(0, 65535) / 65536.0;
          w = $itor($urandom_range(0, span_r - 1)) - 1.0 + $urandom_range(0, 65535) / 65536.0;
          dxr = (cr * u - sr * w) / den * 65536.0;
          dyr = (sr * u + cr * w) / den * 65536.0;
          if (dxr < 1.0e15 && dxr > -1.0e15 && dyr < 1.0e15 && dyr > -1.0e15) begin
            dxl = longint'(dxr);
            dyl = longint'(dyr);
            wx = sh_ox + dxl[31:0];
            wy = sh_oy + dyl[31:0];
          end
        end
        case ($urandom_range(0, 9))
          0: ex = 8'd0;
          1: ex = 8'($urandom_range(253, 255));
          2: ex = 8'd252;
          default: ex = 8'($urandom_range(0, 255));
        endcase
        // never let a query read a cell that has not been loaded
        if (sh_enabled && sh_loaded && locate_cell(wx, wy, flat) && !grid_written[flat])
          send_load(flat[15:0], pick_occupancy());
        noise = {$urandom, $urandom, $urandom};
        push_item(MODE_QUERY, {ex, wy, wx, noise[23:0]});
        costs_due.push_back(merge_cost(wx, wy, ex));
      end
    end
  endtask

  always @(negedge clk) m_axis_tready <= ($urandom_range(0, 99) >= rx_idle);

  always @(posedge clk) begin
    merge_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[7:0], m_axis_tdata[8], m_axis_tdata[9]};
      if (costs_due.size() == 0) begin
        note_mismatch("result with nothing due", '0, got);
      end else begin
        want = costs_due.pop_front();
        if (got !== want) note_mismatch("result mismatch", want, got);
      end
    end
  end

  initial begin
    row_t row;
    sh_enabled = clrm_pkg::RST_LAYER_ENABLED;
    sh_max = clrm_pkg::RST_MAX_COST;
    sh_cols = clrm_pkg::RST_SOURCE_COLUMNS;
    sh_rows = clrm_pkg::RST_SOURCE_ROWS;
    sh_cos = clrm_pkg::RST_SCALED_COSINE;
    sh_sin = clrm_pkg::RST_SCALED_SINE;
    sh_ox = clrm_pkg::RST_ORIGIN_X;
    sh_oy = clrm_pkg::RST_ORIGIN_Y;
    sh_loaded = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      case (row.kind)
        ROW_LOAD: send_load(row.idx, row.val);
        ROW_CFG: begin
          drain_idle();
          write_reg(clrm_pkg::cfg_reg_t'(row.idx[2:0]), row.wx);
        end
        default: begin
          push_item(MODE_QUERY, {row.ex, row.wy, row.wx, 24'h0});
          costs_due.push_back(row.typed ? row.want : merge_cost(row.wx, row.wy, row.ex));
        end
      endcase
    end

    for (int p = 0; p < PHASES; p++) begin
      if (p >= 6) begin
        tx_idle = 0;
        rx_idle = 0;
      end else if (p >= 3) begin
        tx_idle = 83;
        rx_idle = 16;
      end
      drain_idle();
      program_phase(p);
      run_random(PHASE_ITEMS);
    end

    drain_idle();
    if (mismatches == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
